// File: design/sbb_pkg.sv
// Shared constants, types and the divide-by-three helper for the 3x3 box blur.
// Depends on nothing; every other file of the block imports it.
package sbb_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int PIX_W = 16;
  localparam int FW_W  = 12;
  localparam int FH_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0] FW_RESET = 12'd2048;
  localparam logic [FH_W-1:0] FH_RESET = 16'd1080;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Reciprocal of three, exact for every 16-bit dividend after a shift by 17.
  localparam logic [31:0] RECIP3 = 32'd43691;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic col_ge2;
    logic row_ge2;
    logic frame_end;
  } pos_flags_t;

  function automatic pix_t div3(input pix_t s);
    logic [31:0] prod;
    prod = {16'b0, s} * RECIP3;
    return {1'b0, prod[31:17]};
  endfunction

  function automatic pix_t add3(input pix_t a, input pix_t b, input pix_t c);
    logic [PIX_W+1:0] full;
    full = {2'b0, a} + {2'b0, b} + {2'b0, c};
    return full[PIX_W-1:0];
  endfunction

endpackage

// File: design/sbb_line_mem.sv
// Line store: one word per column holding the horizontal values of the two
// rows before, older in the upper half. Depends on sbb_pkg.
module sbb_line_mem
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int AW = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [2*PIX_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [2*PIX_W-1:0] wr_data
);

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/sbb_pos.sv
// Column and row counters of the incoming pixel stream with the frame flags.
// Depends on sbb_pkg.
module sbb_pos
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int CW = $clog2(MAX_WIDTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic [FW_W-1:0] frame_width,
  input  logic [FH_W-1:0] frame_height,
  output logic [CW-1:0]   col,
  output pos_flags_t      flags
);

  localparam int WW = ((CW > FW_W) ? CW : FW_W) + 1;

  logic [CW-1:0]   col_r, col_nxt;
  logic [FH_W-1:0] row_r, row_nxt;
  logic [WW-1:0]   fw_ext, eff_w;
  logic [FH_W-1:0] eff_h;
  logic            last_col, last_row;

  always_comb begin
    fw_ext = WW'(frame_width);
    if (fw_ext < WW'(3)) begin
      eff_w = WW'(3);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (frame_height < 16'd3) ? 16'd3 : frame_height;
    last_col = WW'(col_r) >= (eff_w - WW'(1));
    last_row = row_r >= (eff_h - 16'd1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col             = col_r;
  assign flags.col_ge2   = col_r >= CW'(2);
  assign flags.row_ge2   = row_r >= 16'd2;
  assign flags.frame_end = last_col && last_row;

endmodule

// File: design/separable_box_blur_3x3_core.sv
// Separable 3x3 box blur over a raster stream of 16-bit pixels.
// Results pass the s1, s2 and output registers. Throughput while out_ready does not stall:
// one pixel per cycle, set by the single read and write port of the line store.
// Reset clears the counters, the two-pixel history and the pipeline, and restores the
// frame registers to 2048 by 1080; the line store is not cleared.
// Depends on sbb_pkg, sbb_pos and sbb_line_mem.
module separable_box_blur_3x3_core
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_blurred_value,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  logic            in_acc;
  logic [CW-1:0]   col;
  pos_flags_t      flags;

  pix_t pb1_r, pb2_r;

  logic            s1_v_r, s1_v_nxt;
  logic            s1_prod_r, s1_last_r;
  logic [CW-1:0]   s1_addr_r;
  pix_t            s1_hsum_r;
  logic [2*PIX_W-1:0] rd_data;
  pix_t            hv, older, newer;
  logic            s1_go, s1_free;

  logic            s2_v_r, s2_v_nxt;
  logic            s2_last_r;
  pix_t            s2_vsum_r;
  logic            s2_go, s2_free;

  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  pix_t            out_blurred_r;
  logic            out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s2_go    = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_go    = s1_v_r && (!s1_prod_r || s2_free);
  assign s1_free  = !s1_v_r || s1_go;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && in_ready;

  sbb_pos #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW(CW)
  ) u_pos (
    .clk(clk),
    .rst_n(rst_n),
    .advance(in_acc),
    .frame_width(frame_width_r),
    .frame_height(frame_height_r),
    .col(col),
    .flags(flags)
  );

  sbb_line_mem #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW(CW)
  ) u_line_mem (
    .clk(clk),
    .rd_en(in_acc),
    .rd_addr(col),
    .rd_data(rd_data),
    .wr_en(s1_go),
    .wr_addr(s1_addr_r),
    .wr_data({newer, hv})
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb1_r <= '0;
      pb2_r <= '0;
    end else if (in_acc) begin
      pb1_r <= in_pixel_value;
      pb2_r <= pb1_r;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = flags.col_ge2;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hsum_r <= add3(pb2_r, pb1_r, in_pixel_value);
      s1_addr_r <= col;
      s1_prod_r <= flags.row_ge2;
      s1_last_r <= flags.frame_end;
    end
  end

  assign older = rd_data[2*PIX_W-1:PIX_W];
  assign newer = rd_data[PIX_W-1:0];
  assign hv    = div3(s1_hsum_r);

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s1_go && s1_prod_r) begin
      s2_v_nxt = 1'b1;
    end else if (s2_go) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_prod_r) begin
      s2_vsum_r <= add3(older, newer, hv);
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_blurred_r <= div3(s2_vsum_r);
      out_last_r    <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blurred_value = out_blurred_r;
  assign out_frame_last    = out_last_r;

endmodule
